@@ rtl/core/cds_pkg.sv @@
`default_nettype none

package cds_pkg;

	// Batch and field sizing.
	localparam int MAX_REQUESTS = 32;
	localparam int TRACK_BITS   = 16;
	localparam int IDX_W        = $clog2(MAX_REQUESTS);
	localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
	localparam int SEEK_W       = 22;
	localparam int CFG_W        = TRACK_BITS + 1;
	localparam int CFG_IDX_W    = 1;

	localparam logic [SEEK_W-1:0] SEEK_MAX = {SEEK_W{1'b1}};

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_START_HEAD  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISK_TRACKS = 1'd1;

	// Reset value of the track count: the full track space.
	localparam logic [CFG_W-1:0] DISK_TRACKS_RST = CFG_W'(1) << TRACK_BITS;

	// Source of the track visited by one emitted result.
	typedef logic [1:0] tgt_sel_t;
	localparam tgt_sel_t SEL_MEM  = 2'd0;
	localparam tgt_sel_t SEL_END  = 2'd1;
	localparam tgt_sel_t SEL_ZERO = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     capture;
		logic     rd_en;
		logic     rd_prev;
		logic     ins_shift;
		logic     ins_place;
		logic     em_init;
		logic     skip;
		logic     emit;
		tgt_sel_t emit_sel;
		logic     emit_last;
		logic     idx_inc;
		logic     idx_clr;
		logic     clear_count;
	} cds_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic count_full;
		logic final_q;
		logic idx_zero;
		logic idx_at_count;
		logic idx_last_lo;
		logic split_zero;
		logic rd_lt_head;
		logic rd_gt_new;
		logic head_at_end;
		logic out_free;
	} cds_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/cscan_disk_scheduler_top.sv @@
// C-SCAN disk scheduler. Tracks arrive one per input transfer and are inserted into a
// sorted store of up to 32 entries; a transfer with final_request set closes the batch
// and the block then delivers the service order: requests at or above start_head, the
// disk end (unless the head is already there), track 0, then the lower requests. The
// last result carries the saturating total seek and the batch size. Insertion walks the
// store through its single read port, moving each entry above the new track up one slot.
// Emission walks the whole store and then reads the lower requests again, and it waits
// whenever the output is stalled. The input is held off during insertion and emission;
// configuration writes take effect at once.
`default_nettype none

module cscan_disk_scheduler_top (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_write,
	input  wire logic [cds_pkg::CFG_IDX_W-1:0]          cfg_addr,
	input  wire logic [cds_pkg::CFG_W-1:0]              cfg_wdata,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic [cds_pkg::TRACK_BITS-1:0]         track,
	input  wire logic                                   final_request,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic [cds_pkg::TRACK_BITS-1:0]              visit_track,
	output logic                                        sequence_end,
	output logic [cds_pkg::SEEK_W-1:0]                  total_seek,
	output logic [cds_pkg::CNT_W-1:0]                   batch_size
);

	cds_pkg::cds_cmd_t  cmd;
	cds_pkg::cds_stat_t st;

	// Sequencer for insertion and emission.
	cds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// Store, seek arithmetic and output register.
	cds_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.track         (track),
		.final_request (final_request),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.visit_track   (visit_track),
		.sequence_end  (sequence_end),
		.total_seek    (total_seek),
		.batch_size    (batch_size),
		.cmd           (cmd),
		.st            (st)
	);

endmodule

`default_nettype wire

@@ rtl/core/cds_ctrl.sv @@
`default_nettype none

module cds_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire cds_pkg::cds_stat_t st,
	output cds_pkg::cds_cmd_t     cmd
);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_INS_CHK = 4'd1;
	localparam logic [3:0] ST_INS_CMP = 4'd2;
	localparam logic [3:0] ST_EM_INIT = 4'd3;
	localparam logic [3:0] ST_EM_RD   = 4'd4;
	localparam logic [3:0] ST_EM_UP   = 4'd5;
	localparam logic [3:0] ST_END     = 4'd6;
	localparam logic [3:0] ST_ZERO    = 4'd7;
	localparam logic [3:0] ST_LO_RD   = 4'd8;
	localparam logic [3:0] ST_LO_EM   = 4'd9;
	localparam logic [3:0] ST_FIN     = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and command decode.
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_INS_CHK;
				end
			end
			ST_INS_CHK: begin
				if (st.count_full) begin
					state_d = st.final_q ? ST_EM_INIT : ST_IDLE;
				end else if (st.idx_zero) begin
					cmd.ins_place = 1'b1;
					state_d       = st.final_q ? ST_EM_INIT : ST_IDLE;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_prev = 1'b1;
					state_d     = ST_INS_CMP;
				end
			end
			ST_INS_CMP: begin
				if (st.rd_gt_new) begin
					cmd.ins_shift = 1'b1;
					state_d       = ST_INS_CHK;
				end else begin
					cmd.ins_place = 1'b1;
					state_d       = st.final_q ? ST_EM_INIT : ST_IDLE;
				end
			end
			ST_EM_INIT: begin
				cmd.em_init = 1'b1;
				state_d     = ST_EM_RD;
			end
			ST_EM_RD: begin
				if (st.idx_at_count) begin
					state_d = ST_END;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = ST_EM_UP;
				end
			end
			ST_EM_UP: begin
				if (st.rd_lt_head) begin
					cmd.skip = 1'b1;
					state_d  = ST_EM_RD;
				end else if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = cds_pkg::SEL_MEM;
					cmd.idx_inc  = 1'b1;
					state_d      = ST_EM_RD;
				end
			end
			ST_END: begin
				if (st.head_at_end) begin
					state_d = ST_ZERO;
				end else if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = cds_pkg::SEL_END;
					state_d      = ST_ZERO;
				end
			end
			ST_ZERO: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = cds_pkg::SEL_ZERO;
					cmd.emit_last = st.split_zero;
					cmd.idx_clr   = 1'b1;
					state_d       = st.split_zero ? ST_FIN : ST_LO_RD;
				end
			end
			ST_LO_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_LO_EM;
			end
			ST_LO_EM: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = cds_pkg::SEL_MEM;
					cmd.emit_last = st.idx_last_lo;
					cmd.idx_inc   = 1'b1;
					state_d       = st.idx_last_lo ? ST_FIN : ST_LO_RD;
				end
			end
			ST_FIN: begin
				cmd.clear_count = 1'b1;
				state_d         = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/core/cds_dp.sv @@
`default_nettype none

module cds_dp (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_write,
	input  wire logic [cds_pkg::CFG_IDX_W-1:0]          cfg_addr,
	input  wire logic [cds_pkg::CFG_W-1:0]              cfg_wdata,
	input  wire logic [cds_pkg::TRACK_BITS-1:0]         track,
	input  wire logic                                   final_request,
	input  wire logic                                   out_ready,
	output logic                                        out_valid,
	output logic [cds_pkg::TRACK_BITS-1:0]              visit_track,
	output logic                                        sequence_end,
	output logic [cds_pkg::SEEK_W-1:0]                  total_seek,
	output logic [cds_pkg::CNT_W-1:0]                   batch_size,
	input  wire cds_pkg::cds_cmd_t                      cmd,
	output cds_pkg::cds_stat_t                          st
);

	localparam int TB = cds_pkg::TRACK_BITS;
	localparam int CW = cds_pkg::CNT_W;
	localparam int SW = cds_pkg::SEEK_W;

	// Request store, kept sorted ascending.
	logic [TB-1:0] mem_q [cds_pkg::MAX_REQUESTS];
	logic [TB-1:0] rd_data_q;

	// Configuration registers.
	logic [TB-1:0]              start_head_q;
	logic [cds_pkg::CFG_W-1:0]  disk_tracks_q;

	// Batch bookkeeping and seek state.
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] split_q;
	logic [TB-1:0] new_track_q;
	logic          final_q;
	logic [TB-1:0] head_q;
	logic [SW-1:0] total_q;

	// Output register.
	logic          out_valid_q;
	logic [TB-1:0] visit_track_q;
	logic          sequence_end_q;
	logic [SW-1:0] total_seek_q;
	logic [CW-1:0] batch_size_q;

	logic [cds_pkg::IDX_W-1:0] rd_addr;
	logic [cds_pkg::IDX_W-1:0] wr_addr;
	logic [CW-1:0]             idx_prev;
	logic                      wr_en;
	logic [TB-1:0]             wr_data;
	logic [TB-1:0]             disk_end;
	logic [TB-1:0]             target;
	logic [TB-1:0]             move_dist;
	logic [SW:0]               sum;
	logic [SW-1:0]             move_total;
	logic                      out_free;

	// Configuration writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_head_q  <= '0;
			disk_tracks_q <= cds_pkg::DISK_TRACKS_RST;
		end else if (cfg_write) begin
			unique case (cfg_addr)
				cds_pkg::REG_START_HEAD:  start_head_q  <= cfg_wdata[TB-1:0];
				cds_pkg::REG_DISK_TRACKS: disk_tracks_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Last track of the disk, with zero treated as one track and the count clamped.
	always_comb begin
		if (disk_tracks_q == '0) begin
			disk_end = '0;
		end else if (disk_tracks_q > cds_pkg::DISK_TRACKS_RST) begin
			disk_end = {TB{1'b1}};
		end else begin
			disk_end = TB'(disk_tracks_q - cds_pkg::CFG_W'(1));
		end
	end

	// Memory ports: insertion reads the entry below the slot and shifts it up.
	assign idx_prev = idx_q - CW'(1);
	assign rd_addr  = cmd.rd_prev ? idx_prev[cds_pkg::IDX_W-1:0] : idx_q[cds_pkg::IDX_W-1:0];
	assign wr_addr  = idx_q[cds_pkg::IDX_W-1:0];
	assign wr_en    = cmd.ins_shift | cmd.ins_place;
	assign wr_data  = cmd.ins_shift ? rd_data_q : new_track_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// Head movement and saturating seek total.
	always_comb begin
		case (cmd.emit_sel)
			cds_pkg::SEL_MEM: target = rd_data_q;
			cds_pkg::SEL_END: target = disk_end;
			default:          target = '0;
		endcase
		move_dist  = (head_q > target) ? (head_q - target) : (target - head_q);
		sum        = {1'b0, total_q} + (SW + 1)'(move_dist);
		move_total = sum[SW] ? cds_pkg::SEEK_MAX : sum[SW-1:0];
	end

	// Batch count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear_count) begin
			count_q <= '0;
		end else if (cmd.ins_place) begin
			count_q <= count_q + CW'(1);
		end
	end

	// Walk index, split point, captured request and seek state.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			new_track_q <= track;
			final_q     <= final_request;
			idx_q       <= count_q;
		end
		if (cmd.ins_shift) begin
			idx_q <= idx_prev;
		end
		if (cmd.em_init) begin
			idx_q   <= '0;
			split_q <= '0;
			head_q  <= start_head_q;
			total_q <= '0;
		end
		if (cmd.skip) begin
			idx_q   <= idx_q + CW'(1);
			split_q <= idx_q + CW'(1);
		end
		if (cmd.emit) begin
			head_q  <= target;
			total_q <= move_total;
		end
		if (cmd.idx_inc) begin
			idx_q <= idx_q + CW'(1);
		end
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end
	end

	// Output register: a new result loads when the register is empty or while the previous one is taken.
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			visit_track_q  <= target;
			sequence_end_q <= cmd.emit_last;
			total_seek_q   <= cmd.emit_last ? move_total : '0;
			batch_size_q   <= cmd.emit_last ? count_q : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign visit_track  = visit_track_q;
	assign sequence_end = sequence_end_q;
	assign total_seek   = total_seek_q;
	assign batch_size   = batch_size_q;

	// Status toward the controller.
	always_comb begin
		st              = '0;
		st.count_full   = (count_q == CW'(cds_pkg::MAX_REQUESTS));
		st.final_q      = final_q;
		st.idx_zero     = (idx_q == '0);
		st.idx_at_count = (idx_q == count_q);
		st.idx_last_lo  = ((idx_q + CW'(1)) == split_q);
		st.split_zero   = (split_q == '0);
		st.rd_lt_head   = (rd_data_q < start_head_q);
		st.rd_gt_new    = (rd_data_q > new_track_q);
		st.head_at_end  = (head_q == disk_end);
		st.out_free     = out_free;
	end

	// The batch count never passes the store depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(cds_pkg::MAX_REQUESTS))
		else $error("batch count beyond store depth");

	// A result is loaded only when the output register can take it.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("result loaded over a pending transfer");

	// The closing result of a sequence carries a nonzero batch size.
	a_last_batch: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.emit_last) |=> (batch_size_q != '0))
		else $error("sequence closed with an empty batch");

	// Shift and placement never write the store in the same cycle.
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ins_shift && cmd.ins_place))
		else $error("two store writes in one cycle");

endmodule

`default_nettype wire
